FILE: src/i2c_master_bit_engine_assert.svh
// Assertion macros for the I2C master bit engine.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Antecedent implies consequent on the same edge.
`define I2CM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cm same-cycle check failed");

// Antecedent implies consequent on the following edge.
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cm next-cycle check failed");

`endif

FILE: src/i2cm_pkg.sv
// Types, codes and constants of the I2C master bit engine.
package i2cm_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned CountW = 4;
  localparam int unsigned BitsPerByte = 8;

  localparam logic [DataW-1:0] AckTimeoutRst = 8'd250;
  localparam logic [DataW-1:0] PhaseHoldRst  = 8'd0;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WAIT  = 3'd5
  } cmd_t;

  typedef enum logic {
    REG_PHASE_HOLD  = 1'b0,
    REG_ACK_TIMEOUT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]       command;
    logic [DataW-1:0] data_byte;
    logic             send_ack;
    logic             sda_in;
  } in_item_t;

  typedef struct packed {
    logic             scl_level;
    logic             sda_level;
    logic             sda_drive;
    logic             busy_res;
    logic             done_res;
    logic [DataW-1:0] read_data;
    logic             ack_failed;
  } out_item_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [PhaseW-1:0] phase;
    logic [CountW-1:0] bit_cnt;
    logic [DataW-1:0]  shift;
    logic [DataW-1:0]  hold_cnt;
    logic [DataW-1:0]  poll_cnt;
    logic              scl;
    logic              sda;
    logic              sda_drive;
    logic              ack_fail;
    logic              ack_choice;
    logic [DataW-1:0]  read_data;
  } eng_state_t;

  typedef struct packed {
    logic [DataW-1:0] phase_hold;
    logic [DataW-1:0] ack_timeout;
  } eng_cfg_t;

endpackage

FILE: src/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: input register, tick logic, result register.
// The input register feeds the tick logic, whose result is held in the result register on out_valid.
// Throughput: one transaction per cycle while the result side does not stall.
// Stall on the result side holds the result register and backs up into in_stall.
// Reset (rst_n low, synchronous): bus released (SCL and SDA high, SDA driven), engine idle,
// phase_hold 0, ack_timeout 250, read data and ack failure cleared, no pending transactions.
module i2c_master_bit_engine import i2cm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [DataW-1:0] cfg_wdata
);

`include "i2c_master_bit_engine_assert.svh"

  logic       in_q_valid_r, in_q_valid_nxt;
  in_item_t   in_q_r;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r;
  eng_state_t state_r, state_nxt;
  eng_cfg_t   cfg_r, cfg_nxt;
  out_item_t  result;
  logic       advance;
  logic       in_take;

  assign advance  = in_q_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_q_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  i2cm_step u_step (
    .state_i  (state_r),
    .item_i   (in_q_r),
    .cfg_i    (cfg_r),
    .state_o  (state_nxt),
    .result_o (result)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PHASE_HOLD:  cfg_nxt.phase_hold  = cfg_wdata;
        REG_ACK_TIMEOUT: cfg_nxt.ack_timeout = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_q_valid_nxt = in_take || (in_q_valid_r && !advance);
  assign out_valid_nxt  = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r          <= 1'b0;
      out_valid_r           <= 1'b0;
      cfg_r.phase_hold      <= PhaseHoldRst;
      cfg_r.ack_timeout     <= AckTimeoutRst;
      state_r.cmd           <= CMD_NONE;
      state_r.phase         <= '0;
      state_r.bit_cnt       <= '0;
      state_r.shift         <= '0;
      state_r.hold_cnt      <= '0;
      state_r.poll_cnt      <= '0;
      state_r.scl           <= 1'b1;
      state_r.sda           <= 1'b1;
      state_r.sda_drive     <= 1'b1;
      state_r.ack_fail      <= 1'b0;
      state_r.ack_choice    <= 1'b0;
      state_r.read_data     <= '0;
    end else begin
      in_q_valid_r <= in_q_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      cfg_r        <= cfg_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_r <= in_data;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `I2CM_ASSERT_SAME(a_done_not_busy, clk, rst_n, out_valid_r && out_r.done_res, !out_r.busy_res)
  `I2CM_ASSERT_NEXT(a_state_holds, clk, rst_n, !advance, $stable(state_r))
  `I2CM_ASSERT_NEXT(a_busy_tracks, clk, rst_n, advance, out_r.busy_res == (state_r.cmd != CMD_NONE))
  `I2CM_ASSERT_NEXT(a_fail_tracks, clk, rst_n, advance, out_r.ack_failed == state_r.ack_fail)

endmodule

FILE: src/i2cm_step.sv
// Per-tick next-state and pin logic of the I2C master bit engine.
module i2cm_step import i2cm_pkg::*; (
  input  eng_state_t state_i,
  input  in_item_t   item_i,
  input  eng_cfg_t   cfg_i,
  output eng_state_t state_o,
  output out_item_t  result_o
);

  function automatic eng_state_t finish_f(eng_state_t st);
    eng_state_t r;
    r          = st;
    r.cmd      = CMD_NONE;
    r.phase    = '0;
    r.bit_cnt  = '0;
    r.hold_cnt = '0;
    r.poll_cnt = '0;
    return r;
  endfunction

  eng_state_t    s;
  logic          done;
  logic          over;
  logic [DataW:0] poll_inc;

  always_comb begin
    s        = state_i;
    done     = 1'b0;
    over     = 1'b0;
    poll_inc = '0;

    // launch a new command only when idle
    if (s.cmd == CMD_NONE && item_i.command >= CMD_START && item_i.command <= CMD_WAIT) begin
      s.cmd      = cmd_t'(item_i.command);
      s.phase    = '0;
      s.bit_cnt  = '0;
      s.hold_cnt = '0;
      s.poll_cnt = '0;
      if (s.cmd == CMD_SEND) begin
        s.shift = item_i.data_byte;
      end
      if (s.cmd == CMD_READ) begin
        s.shift      = '0;
        s.ack_choice = item_i.send_ack;
      end
      if (s.cmd == CMD_WAIT) begin
        s.ack_fail = 1'b0;
      end
    end

    unique case (s.cmd)
      CMD_START: begin
        if (s.phase == 4'd0) begin
          s.sda_drive = 1'b1;
          s.sda       = 1'b1;
          s.scl       = 1'b1;
        end else if (s.phase == 4'd1) begin
          s.sda = 1'b0;
        end else begin
          s.scl = 1'b0;
        end
        over = (s.hold_cnt >= cfg_i.phase_hold);
        if (over) begin
          s.hold_cnt = '0;
          if (s.phase >= 4'd2) begin
            s    = finish_f(s);
            done = 1'b1;
          end else begin
            s.phase = s.phase + 4'd1;
          end
        end else begin
          s.hold_cnt = s.hold_cnt + 8'd1;
        end
      end
      CMD_STOP: begin
        if (s.phase == 4'd0) begin
          s.sda_drive = 1'b1;
          s.scl       = 1'b0;
          s.sda       = 1'b0;
        end else begin
          s.scl = 1'b1;
          s.sda = 1'b1;
        end
        over = (s.hold_cnt >= cfg_i.phase_hold);
        if (over) begin
          s.hold_cnt = '0;
          if (s.phase >= 4'd1) begin
            s    = finish_f(s);
            done = 1'b1;
          end else begin
            s.phase = s.phase + 4'd1;
          end
        end else begin
          s.hold_cnt = s.hold_cnt + 8'd1;
        end
      end
      CMD_SEND: begin
        if (s.phase == 4'd0) begin
          s.sda_drive = 1'b1;
          s.scl       = 1'b0;
          s.sda       = s.shift[DataW-1];
        end else if (s.phase == 4'd1) begin
          s.scl = 1'b1;
        end else begin
          s.scl = 1'b0;
        end
        over = (s.hold_cnt >= cfg_i.phase_hold);
        if (over) begin
          s.hold_cnt = '0;
          if (s.phase >= 4'd2) begin
            s.shift   = {s.shift[DataW-2:0], 1'b0};
            s.bit_cnt = s.bit_cnt + 4'd1;
            if (s.bit_cnt >= CountW'(BitsPerByte)) begin
              s    = finish_f(s);
              done = 1'b1;
            end else begin
              s.phase = '0;
            end
          end else begin
            s.phase = s.phase + 4'd1;
          end
        end else begin
          s.hold_cnt = s.hold_cnt + 8'd1;
        end
      end
      CMD_READ: begin
        if (s.phase == 4'd0) begin
          s.sda_drive = 1'b0;
          s.scl       = 1'b0;
        end else if (s.phase == 4'd1) begin
          s.scl = 1'b1;
          if (s.hold_cnt == '0) begin
            s.shift = {s.shift[DataW-2:0], item_i.sda_in};
          end
        end else if (s.phase == 4'd2) begin
          s.scl       = 1'b0;
          s.sda_drive = 1'b1;
          s.sda       = ~s.ack_choice;
        end else if (s.phase == 4'd3) begin
          s.scl = 1'b1;
        end else begin
          s.scl = 1'b0;
        end
        over = (s.hold_cnt >= cfg_i.phase_hold);
        if (over) begin
          s.hold_cnt = '0;
          if (s.phase == 4'd1) begin
            s.bit_cnt = s.bit_cnt + 4'd1;
            s.phase   = (s.bit_cnt >= CountW'(BitsPerByte)) ? 4'd2 : 4'd0;
          end else if (s.phase >= 4'd4) begin
            s.read_data = s.shift;
            s           = finish_f(s);
            done        = 1'b1;
          end else begin
            s.phase = s.phase + 4'd1;
          end
        end else begin
          s.hold_cnt = s.hold_cnt + 8'd1;
        end
      end
      CMD_WAIT: begin
        if (s.phase == 4'd0) begin
          s.sda_drive = 1'b1;
          s.sda       = 1'b1;
          over = (s.hold_cnt >= cfg_i.phase_hold);
          if (over) begin
            s.hold_cnt = '0;
            s.phase    = 4'd1;
          end else begin
            s.hold_cnt = s.hold_cnt + 8'd1;
          end
        end else if (s.phase == 4'd1) begin
          s.scl = 1'b1;
          over = (s.hold_cnt >= cfg_i.phase_hold);
          if (over) begin
            s.hold_cnt = '0;
            s.phase    = 4'd2;
          end else begin
            s.hold_cnt = s.hold_cnt + 8'd1;
          end
        end else begin
          s.sda_drive = 1'b0;
          poll_inc    = {1'b0, s.poll_cnt} + 9'd1;
          if (!item_i.sda_in) begin
            s.scl      = 1'b0;
            s.ack_fail = 1'b0;
            s          = finish_f(s);
            done       = 1'b1;
          end else if (poll_inc > {1'b0, cfg_i.ack_timeout}) begin
            // timeout: enter the first stop phase on this tick
            s.ack_fail  = 1'b1;
            s.cmd       = CMD_STOP;
            s.poll_cnt  = '0;
            s.sda_drive = 1'b1;
            s.scl       = 1'b0;
            s.sda       = 1'b0;
            if (cfg_i.phase_hold == '0) begin
              s.hold_cnt = '0;
              s.phase    = 4'd1;
            end else begin
              s.hold_cnt = 8'd1;
              s.phase    = 4'd0;
            end
          end else begin
            s.poll_cnt = poll_inc[DataW-1:0];
          end
        end
      end
      default: begin
      end
    endcase

    state_o            = s;
    result_o.scl_level  = s.scl;
    result_o.sda_level  = s.sda;
    result_o.sda_drive  = s.sda_drive;
    result_o.busy_res   = (s.cmd != CMD_NONE);
    result_o.done_res   = done;
    result_o.read_data  = s.read_data;
    result_o.ack_failed = s.ack_fail;
  end

endmodule
